FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int USE_W   = 16;
  localparam int STAMP_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(ENTRIES);

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
  } rsp_t;

  typedef struct packed {
    logic               live;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [DATA_W-1:0]  hit_data;
    logic [CNT_W-1:0]   used;
    logic               free_ok;
    logic [IDX_W-1:0]   free_idx;
    logic               vic_ok;
    logic [IDX_W-1:0]   vic_idx;
    logic [USE_W-1:0]   vic_cnt;
    logic [STAMP_W-1:0] vic_stamp;
  } scan_t;

  typedef struct packed {
    logic               en;
    logic               fill;
    logic               bump;
    logic               set_data;
    logic [IDX_W-1:0]   slot;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

endpackage

FILE: hdl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell
// One cache entry. Passes the scan record to its neighbor and applies updates.
// ----------------------------------------------------------------------------
module lfu_cell import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic [KEY_W-1:0] key,
  input  scan_t            scan_in,
  output scan_t            scan_out,
  input  cmd_t             cmd
);

  logic               valid;
  logic [KEY_W-1:0]   ekey;
  logic [DATA_W-1:0]  data;
  logic [USE_W-1:0]   cnt;
  logic [STAMP_W-1:0] stamp;
  scan_t              scan_next;

  always_comb begin
    scan_next = scan_in;
    if (scan_in.live) begin
      if (valid) begin
        scan_next.used = scan_in.used + CNT_W'(1);
        if (!scan_in.hit && ekey == key) begin
          scan_next.hit      = 1'b1;
          scan_next.hit_idx  = idx;
          scan_next.hit_data = data;
        end
        if (!scan_in.vic_ok || {cnt, stamp} < {scan_in.vic_cnt, scan_in.vic_stamp}) begin
          scan_next.vic_ok    = 1'b1;
          scan_next.vic_idx   = idx;
          scan_next.vic_cnt   = cnt;
          scan_next.vic_stamp = stamp;
        end
      end else if (!scan_in.free_ok) begin
        scan_next.free_ok  = 1'b1;
        scan_next.free_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      scan_out.live <= 1'b0;
    end else begin
      scan_out.live <= scan_next.live;
      if (cmd.en && cmd.slot == idx && cmd.fill) begin
        valid <= 1'b1;
      end
    end
    scan_out.hit       <= scan_next.hit;
    scan_out.hit_idx   <= scan_next.hit_idx;
    scan_out.hit_data  <= scan_next.hit_data;
    scan_out.used      <= scan_next.used;
    scan_out.free_ok   <= scan_next.free_ok;
    scan_out.free_idx  <= scan_next.free_idx;
    scan_out.vic_ok    <= scan_next.vic_ok;
    scan_out.vic_idx   <= scan_next.vic_idx;
    scan_out.vic_cnt   <= scan_next.vic_cnt;
    scan_out.vic_stamp <= scan_next.vic_stamp;
    if (cmd.en && cmd.slot == idx) begin
      if (cmd.fill) begin
        ekey  <= cmd.key;
        data  <= cmd.data;
        cnt   <= USE_W'(1);
        stamp <= cmd.stamp;
      end else if (cmd.bump) begin
        if (cnt != '1) begin
          cnt <= cnt + USE_W'(1);
        end
        stamp <= cmd.stamp;
        if (cmd.set_data) begin
          data <= cmd.data;
        end
      end
    end
  end

endmodule

FILE: hdl/lfu_cache_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_unit
// LFU key/value cache built as a chain of entry cells with LRU tie-break.
// ----------------------------------------------------------------------------
// A request is taken in S_IDLE, launched down the cell chain in S_LAUNCH,
// awaited at the chain end in S_SCAN, applied in S_UPDATE and answered from
// S_RESP, which waits on rsp_stall. One transaction is in flight at a time.
// Synchronous reset clears all entry valid bits, the stamp counter and sets
// capacity to 16; it needs no clearing pass.
module lfu_cache_unit import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             wr_en,
  input  logic [CAP_W-1:0] wr_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_LAUNCH, S_SCAN, S_UPDATE, S_RESP
  } state_t;

  state_t             state;
  req_t               cur;
  scan_t              res;
  rsp_t               pend;
  logic [CAP_W-1:0]   capacity;
  logic [STAMP_W-1:0] stamp_ctr;
  scan_t              chain [ENTRIES+1];
  cmd_t               cmd;
  rsp_t               rsp_next;
  logic [CAP_W-1:0]   cap;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    chain[0]      = '0;
    chain[0].live = (state == S_LAUNCH);
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(g)),
      .key      (cur.key),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1]),
      .cmd      (cmd)
    );
  end

  always_comb begin
    cap       = (capacity > CAP_MAX) ? CAP_MAX : capacity;
    cmd       = '0;
    cmd.key   = cur.key;
    cmd.data  = cur.value;
    cmd.stamp = stamp_ctr;
    rsp_next  = '0;
    rsp_next.hit = res.hit;
    if (state == S_UPDATE) begin
      if (cur.mode == MODE_GET) begin
        if (res.hit) begin
          rsp_next.read_value = res.hit_data;
          cmd.en   = 1'b1;
          cmd.bump = 1'b1;
          cmd.slot = res.hit_idx;
        end
      end else if (cap != '0) begin
        if (res.hit) begin
          cmd.en       = 1'b1;
          cmd.bump     = 1'b1;
          cmd.set_data = 1'b1;
          cmd.slot     = res.hit_idx;
        end else if (CAP_W'(res.used) >= cap || !res.free_ok) begin
          if (res.vic_ok) begin
            cmd.en           = 1'b1;
            cmd.fill         = 1'b1;
            cmd.slot         = res.vic_idx;
            rsp_next.evicted = 1'b1;
          end
        end else begin
          cmd.en   = 1'b1;
          cmd.fill = 1'b1;
          cmd.slot = res.free_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      stamp_ctr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        capacity <= wr_data;
      end
      if (cmd.en) begin
        stamp_ctr <= stamp_ctr + STAMP_W'(1);
      end
      if (rsp_valid && !rsp_stall && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: state <= S_SCAN;
        S_SCAN: begin
          if (chain[ENTRIES].live) begin
            res   <= chain[ENTRIES];
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          pend  <= rsp_next;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_evict_on_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.evicted))
    else $error("eviction reported together with a hit");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.read_value == '0))
    else $error("miss returned nonzero data");

  a_scan_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[ENTRIES].live |-> (state == S_SCAN))
    else $error("scan record reached chain end outside scan state");
`endif

endmodule
